FILE: rtl/tfs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the floor search block.
package tfs_pkg;

    // Default table depth.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Fixed field widths of the request and result items.
    localparam int IDX_W  = 10;
    localparam int TIME_W = 64;

    // Operation codes carried in the request's tuser.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;     // write the request's timestamp into the table
        logic load;      // capture key and saturated range of a search
        logic addr_low;  // read the entry at the low index
        logic chk_low;   // evaluate the low entry against the key
        logic probe;     // evaluate one probe and narrow the range
        logic out_load;  // move the final answer into the result register
    } tfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic below;     // key lies under the low entry
        logic more;      // the narrowed range still holds more than one entry
    } tfs_status_t;

endpackage

FILE: rtl/tfs_ram.sv
// Generic single-port RAM with registered read data.
module tfs_ram
    import tfs_pkg::*;
#(
    parameter int WIDTH = TIME_W,
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/tfs_ctrl.sv
// Controller state machine that sequences table writes and the probes of a search.
module tfs_ctrl
    import tfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        req_valid,
    input  logic        req_search,
    input  tfs_status_t status,
    input  logic        res_ready,
    output logic        req_ready,
    output logic        res_valid,
    output tfs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOW_ADDR,
        ST_LOW_CHK,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    if (req_search == FUNC_SEARCH) begin
                        cmd.load   = 1'b1;
                        state_next = ST_LOW_ADDR;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_LOW_ADDR: begin
                cmd.addr_low = 1'b1;
                state_next   = ST_LOW_CHK;
            end
            ST_LOW_CHK: begin
                cmd.chk_low = 1'b1;
                state_next  = (status.below || !status.more) ? ST_DONE : ST_PROBE;
            end
            ST_PROBE: begin
                cmd.probe = 1'b1;
                if (!status.more) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!res_valid_reg || res_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

FILE: rtl/tfs_dpath.sv
// Search datapath: range registers, probe midpoint, key compare and result register.
module tfs_dpath
    import tfs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  tfs_cmd_t                       cmd,
    output tfs_status_t                    status,
    input  logic [IDX_W-1:0]               entry_index,
    input  logic [TIME_W-1:0]              time_value,
    input  logic [IDX_W-1:0]               low_index,
    input  logic [IDX_W-1:0]               high_index,
    output logic                           ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_addr,
    output logic [TIME_W-1:0]              ram_wdata,
    input  logic [TIME_W-1:0]              ram_rdata,
    output logic [IDX_W-1:0]               found_index,
    output logic                           exact_match,
    output logic                           below_range
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    // Positions never exceed the smaller of the field range and the table.
    localparam int IXW = (AW < IDX_W) ? AW : IDX_W;
    localparam logic [IXW-1:0] LAST_POS = IXW'(TABLE_DEPTH - 1);

    logic [TIME_W-1:0] key_reg;
    logic [IXW-1:0]    l_reg, h_reg, mid_reg;
    logic              exact_reg, below_reg;
    logic [IXW-1:0]    found_reg;
    logic              out_exact_reg, out_below_reg;

    logic [IXW-1:0]    low_sat, high_sat;
    logic              rd_le, rd_eq;
    logic [IXW-1:0]    l_new, h_new, mid_new;
    logic [IXW:0]      span;

    always_comb begin
        low_sat  = (32'(low_index) >= TABLE_DEPTH) ? LAST_POS : IXW'(low_index);
        high_sat = (32'(high_index) >= TABLE_DEPTH) ? LAST_POS : IXW'(high_index);
    end

    assign rd_le = (ram_rdata <= key_reg);
    assign rd_eq = (ram_rdata == key_reg);

    // During a probe the entry read at mid_reg narrows the range.
    always_comb begin
        if (cmd.probe && rd_le) begin
            l_new = mid_reg;
            h_new = h_reg;
        end else if (cmd.probe) begin
            l_new = l_reg;
            h_new = mid_reg - 1'b1;
        end else begin
            l_new = l_reg;
            h_new = h_reg;
        end
        span    = {1'b0, h_new} - {1'b0, l_new} + 1'b1;
        mid_new = l_new + span[IXW:1];
    end

    assign status.below = !rd_le;
    assign status.more  = (l_new < h_new);

    assign ram_we    = cmd.wr_en && (32'(entry_index) < TABLE_DEPTH);
    assign ram_wdata = time_value;

    always_comb begin
        if (cmd.wr_en) begin
            ram_addr = AW'(entry_index);
        end else if (cmd.addr_low) begin
            ram_addr = AW'(l_reg);
        end else begin
            ram_addr = AW'(mid_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= time_value;
            l_reg   <= low_sat;
            h_reg   <= (high_sat < low_sat) ? low_sat : high_sat;
        end
        if (cmd.chk_low) begin
            below_reg <= !rd_le;
            exact_reg <= rd_eq;
            mid_reg   <= mid_new;
        end
        if (cmd.probe) begin
            l_reg   <= l_new;
            h_reg   <= h_new;
            mid_reg <= mid_new;
            if (rd_le) begin
                exact_reg <= rd_eq;
            end
        end
        if (cmd.out_load) begin
            found_reg     <= l_reg;
            out_exact_reg <= exact_reg && !below_reg;
            out_below_reg <= below_reg;
        end
    end

    assign found_index = IDX_W'(found_reg);
    assign exact_match = out_exact_reg;
    assign below_range = out_below_reg;

endmodule

FILE: rtl/timestamp_floor_search_top.sv
// Top level of the floor search over a sorted table of timestamps.
// Timing: a write request is taken while idle and gives no result. A search steps through
//   load, low-entry read and check, probes and done; a key below the low entry skips probes.
// Flow: one request at a time; a search holds the request side closed until its result is
//   loaded, and the next request is taken even while a result still waits.
// Reset: aresetn (synchronous, active low) clears control and result valid; the table is kept.
module timestamp_floor_search_top
    import tfs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: entry_index[9:0], time_value[73:10], low_index[83:74],
    // high_index[93:84], zero padding[95:94].
    input  logic [95:0] s_tdata,
    // Bit 0: func (0 write, 1 search).
    input  logic [0:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: found_index[9:0], zero padding[15:10].
    output logic [15:0] m_tdata,
    // From bit 0: exact_match[0], below_range[1].
    output logic [1:0]  m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);

    tfs_cmd_t          cmd;
    tfs_status_t       status;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [TIME_W-1:0] ram_wdata, ram_rdata;
    logic [IDX_W-1:0]  found_index;
    logic              exact_match, below_range;

    // The controller decides when requests are taken and which step the
    // datapath performs; it also owns the result valid flag.
    tfs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_search (s_tuser[0]),
        .status     (status),
        .res_ready  (m_tready),
        .req_ready  (s_tready),
        .res_valid  (m_tvalid),
        .cmd        (cmd)
    );

    // The datapath holds the key and the shrinking range, computes each probe
    // address and keeps the answer in the result register.
    tfs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .entry_index (s_tdata[9:0]),
        .time_value  (s_tdata[73:10]),
        .low_index   (s_tdata[83:74]),
        .high_index  (s_tdata[93:84]),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .ram_rdata   (ram_rdata),
        .found_index (found_index),
        .exact_match (exact_match),
        .below_range (below_range)
    );

    // The timestamp table: one port, written by write requests and read at
    // the low entry and once per probe during a search.
    tfs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_tdata = {6'b0, found_index};
    assign m_tuser = {below_range, exact_match};

    // A key below the range never reports an exact match.
    a_below_not_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("below-range result flags an exact match");

    // Every reported position lies inside the table.
    a_found_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[9:0]) < TABLE_DEPTH))
        else $error("found index beyond table depth");

    // A write request never produces a result.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_WRITE) && !m_tvalid |=> !m_tvalid)
        else $error("write request produced a result");

    // A search keeps the request side closed while it runs.
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_SEARCH) |=> !s_tready)
        else $error("request taken while a search is running");

endmodule
